[rtl/core/gwcr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwcr_pkg
// Types, constants and helpers shared by the free group word compose/reduce
// block: request/result payloads, controller states and command/status groups.
// ---------------------------------------------------------------------------
package gwcr_pkg;

	localparam int ELEM_W       = 28;
	localparam int CNT_W        = 3;
	localparam int GEN_W        = 5;
	localparam int LEN_W        = 4;
	localparam int ELEM_SLOTS   = 5;
	localparam int UNPACK_SLOTS = 8;
	localparam int PAD_W        = CNT_W + GEN_W * UNPACK_SLOTS;

	localparam logic [GEN_W-1:0] GEN_INV = GEN_W'(16);

	typedef enum logic {
		ACT_COMPOSE = 1'b0,
		ACT_INVERT  = 1'b1
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [ELEM_W-1:0] first_element;
		logic [ELEM_W-1:0] second_element;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] result_element;
		logic [LEN_W-1:0]  result_length;
		logic              too_long;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REDUCE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic need_reduce;
		logic last;
	} dp_stat_t;

	typedef logic [UNPACK_SLOTS-1:0][GEN_W-1:0] gen_arr_t;

	// split an element into generator slots; slots past bit 27 read as zero
	function automatic gen_arr_t unpack_gens(input logic [ELEM_W-1:0] elem);
		logic [PAD_W-1:0] pad;
		gen_arr_t         g;
		pad = PAD_W'(elem);
		for (int k = 0; k < UNPACK_SLOTS; k++) begin
			g[k] = pad[CNT_W + GEN_W * k +: GEN_W];
		end
		return g;
	endfunction

endpackage

[rtl/core/gwcr_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwcr_ctrl
// Sequencer: accept a request, decode it, step the cancellation stack once
// per generator when needed, then present the result for one cycle.
// ---------------------------------------------------------------------------
module gwcr_ctrl import gwcr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = stat.need_reduce ? ST_REDUCE : ST_RESULT;
			end
			ST_REDUCE: begin
				if (stat.last) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
			end
			ST_REDUCE: begin
				cmd.step = 1'b1;
			end
			ST_RESULT: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/gwcr_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwcr_datapath
// Request latch, combined word builder, cancellation stack and result packer.
// ---------------------------------------------------------------------------
module gwcr_datapath import gwcr_pkg::*; #(
	parameter int MAX_GENS = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  req_t     req,
	output rsp_t     rsp
);

	localparam int DEPTH      = 2 * MAX_GENS;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PACK_SLOTS = (DEPTH < ELEM_SLOTS) ? DEPTH : ELEM_SLOTS;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GENS);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_GENS);

	req_t             req_q;
	logic [GEN_W-1:0] word_q [DEPTH];
	logic [GEN_W-1:0] stk_q  [DEPTH];
	logic [LEN_W-1:0] total_q;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] sp_q;
	logic             bad_q;
	logic             reduce_q;

	logic [CNT_W-1:0] n1;
	logic [CNT_W-1:0] n2;
	gen_arr_t         g1;
	gen_arr_t         g2;
	logic             bad_d;
	logic [LEN_W-1:0] total_d;
	logic             reduce_d;
	logic [GEN_W-1:0] word_d [DEPTH];

	logic [GEN_W-1:0] cur_gen;
	logic [GEN_W-1:0] top_gen;
	logic [LEN_W-1:0] sp_m1;
	logic             cancel;

	// decode the latched request
	always_comb begin
		logic [LEN_W-1:0] n1_x;
		logic [LEN_W-1:0] n2_x;
		logic [LEN_W-1:0] iv;
		logic [LEN_W-1:0] off;
		n1   = req_q.first_element[CNT_W-1:0];
		n2   = req_q.second_element[CNT_W-1:0];
		n1_x = LEN_W'(n1);
		n2_x = LEN_W'(n2);
		off  = '0;
		g1   = unpack_gens(req_q.first_element);
		g2   = unpack_gens(req_q.second_element);
		if (req_q.action == ACT_INVERT) begin
			bad_d   = (n1 > MAX_CNT);
			total_d = n1_x;
		end else begin
			bad_d   = (n1 > MAX_CNT) || (n2 > MAX_CNT);
			total_d = n1_x + n2_x;
		end
		reduce_d = !bad_d && (req_q.action == ACT_COMPOSE) && (total_d > MAX_LEN);
		for (int i = 0; i < DEPTH; i++) begin
			iv = LEN_W'(i);
			if (req_q.action == ACT_INVERT) begin
				off       = n1_x - LEN_W'(1) - iv;
				word_d[i] = g1[off[CNT_W-1:0]] ^ GEN_INV;
			end else if (iv < n2_x) begin
				word_d[i] = g2[iv[CNT_W-1:0]];
			end else begin
				off       = iv - n2_x;
				word_d[i] = g1[off[CNT_W-1:0]];
			end
		end
	end

	// one stack step
	assign sp_m1   = sp_q - LEN_W'(1);
	assign cur_gen = word_q[idx_q];
	assign top_gen = stk_q[sp_m1[IDX_W-1:0]];
	assign cancel  = (sp_q != '0) && ((top_gen ^ cur_gen) == GEN_INV);

	assign stat.need_reduce = reduce_d;
	assign stat.last        = (LEN_W'(idx_q) == (total_q - LEN_W'(1)));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.decode) begin
			word_q  <= word_d;
			total_q <= total_d;
		end
		if (cmd.step && !cancel) begin
			stk_q[sp_q[IDX_W-1:0]] <= cur_gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			sp_q     <= '0;
			bad_q    <= 1'b0;
			reduce_q <= 1'b0;
		end else if (cmd.decode) begin
			idx_q    <= '0;
			sp_q     <= '0;
			bad_q    <= bad_d;
			reduce_q <= reduce_d;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			sp_q  <= cancel ? sp_m1 : sp_q + LEN_W'(1);
		end
	end

	// pack the result
	always_comb begin
		logic [LEN_W-1:0]  len_sel;
		logic [ELEM_W-1:0] elem;
		len_sel = reduce_q ? sp_q : total_q;
		elem    = ELEM_W'(len_sel[CNT_W-1:0]);
		for (int k = 0; k < PACK_SLOTS; k++) begin
			if (LEN_W'(k) < len_sel) begin
				elem[CNT_W + GEN_W * k +: GEN_W] = reduce_q ? stk_q[k] : word_q[k];
			end
		end
		if (bad_q) begin
			rsp.result_element = '0;
			rsp.result_length  = '0;
			rsp.too_long       = 1'b1;
		end else if (reduce_q && (sp_q > MAX_LEN)) begin
			rsp.result_element = '0;
			rsp.result_length  = sp_q;
			rsp.too_long       = 1'b1;
		end else begin
			rsp.result_element = elem;
			rsp.result_length  = len_sel;
			rsp.too_long       = 1'b0;
		end
	end

endmodule

[rtl/core/group_word_compose_reduce.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// group_word_compose_reduce
// Compose or invert packed free group words, cancelling adjacent inverse
// pairs with a stack when the combined word is longer than MAX_GENS.
// ---------------------------------------------------------------------------
//  channel   | handshake           | payload
//  request   | start, busy         | request (req_t)
//  result    | done (one cycle)    | result (rsp_t)
//
//  An accepted request is decoded, then, when the combined word needs
//  reduction, the cancellation stack takes one step per generator (up to
//  2*MAX_GENS generators), then the result is shown with done high for
//  one cycle; busy drops the cycle after done. Reset clears the sequencer
//  and stack pointer. The receiver cannot stall.
// ---------------------------------------------------------------------------
module group_word_compose_reduce import gwcr_pkg::*; #(
	parameter int MAX_GENS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gwcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	gwcr_datapath #(
		.MAX_GENS (MAX_GENS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (request),
		.rsp    (result)
	);

endmodule

[rtl/core/gwcr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gwcr_checker
// Port-level checks on request/result sequencing and result encoding.
// ---------------------------------------------------------------------------
module gwcr_checker import gwcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.too_long) |-> (result.result_element == '0))
		else $error("too_long result carries a nonzero element");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.too_long) |->
		(result.result_element[CNT_W-1:0] == result.result_length[CNT_W-1:0]))
		else $error("result count field disagrees with length");

endmodule

bind group_word_compose_reduce gwcr_checker u_gwcr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
